[design/cbrb_pkg.sv]
// chunked byte ring buffer: shared types and constants
// no dependencies; imported by chunked_byte_ring_buffer_top
package cbrb_pkg;

    localparam int CAPACITY = 4096;
    localparam int PTR_W    = 12;
    localparam int CNT_W    = 13;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_PEEK    = 2'd1;
    localparam logic [1:0] OP_CONSUME = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic             first;
        logic [CNT_W-1:0] write_length;
        logic [7:0]       data_byte;
        logic [CNT_W-1:0] consume_length;
        logic [PTR_W-1:0] position;
    } cbrb_req_t;

    typedef struct packed {
        logic             ok;
        logic [PTR_W-1:0] begin_index;
        logic [CNT_W-1:0] slice0_length;
        logic [CNT_W-1:0] slice1_length;
        logic [7:0]       read_byte;
    } cbrb_rsp_t;

endpackage

[design/chunked_byte_ring_buffer_top.sv]
// chunked byte ring buffer, top level; depends on cbrb_pkg.
// A 4096-byte ring that takes variable-length writes (an opening transaction
// with the length, then one transaction per data byte), peek, consume and
// read requests. One transaction is taken every clock cycle: busy is never
// raised, and the result of each transaction appears on response with done
// high for exactly one cycle, in the cycle after acceptance. Results are
// registered like the byte store, a synchronous memory with one write and one
// read port and registered read data; the pointers and counts update at
// acceptance, so a read may follow a write to the same entry in the next cycle.
// The receiver cannot stall results. The store needs no clearing after reset.
module chunked_byte_ring_buffer_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cbrb_pkg::cbrb_req_t request,
    output logic              done,
    output cbrb_pkg::cbrb_rsp_t response
);
    import cbrb_pkg::*;

    logic [7:0] byte_store [CAPACITY];

    logic [PTR_W-1:0] begin_ptr_reg, begin_ptr_next;
    logic [PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [CNT_W-1:0] stored_count_reg, stored_count_next;
    logic [CNT_W-1:0] remaining_reg, remaining_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic             dropping_reg, dropping_next;
    logic             done_reg;

    logic             ok_reg, ok_next;
    logic [PTR_W-1:0] bidx_reg, bidx_next;
    logic [CNT_W-1:0] s0_reg, s0_next;
    logic [CNT_W-1:0] s1_reg, s1_next;
    logic             rd_sel_reg, rd_sel_next;
    logic [7:0]       rd_data_reg;

    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [CNT_W-1:0] free_space;
    logic [CNT_W:0]   peek_end;
    logic [CNT_W:0]   begin_sum;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign free_space = CNT_W'(CAPACITY) - stored_count_reg;
    assign peek_end   = {2'b00, begin_ptr_reg} + {1'b0, stored_count_reg};
    assign begin_sum  = {2'b00, begin_ptr_reg} + {1'b0, request.consume_length};

    always_comb
    begin
        begin_ptr_next    = begin_ptr_reg;
        write_ptr_next    = write_ptr_reg;
        stored_count_next = stored_count_reg;
        remaining_next    = remaining_reg;
        pending_next      = pending_reg;
        dropping_next     = dropping_reg;
        ok_next           = 1'b0;
        bidx_next         = '0;
        s0_next           = '0;
        s1_next           = '0;
        rd_sel_next       = 1'b0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        if (accept)
        begin
            unique case (request.op)
                OP_WRITE:
                begin
                    if (request.first)
                    begin
                        // an open write keeps going; the new opener is refused
                        priority if (remaining_reg != '0)
                        begin
                            ok_next = 1'b0;
                        end
                        else if (request.write_length > free_space)
                        begin
                            dropping_next = 1'b1;
                        end
                        else
                        begin
                            dropping_next  = 1'b0;
                            remaining_next = request.write_length;
                            pending_next   = request.write_length;
                            ok_next        = 1'b1;
                        end
                    end
                    else if (!dropping_reg && remaining_reg != '0)
                    begin
                        wr_en          = 1'b1;
                        write_ptr_next = (write_ptr_reg == PTR_W'(CAPACITY - 1)) ?
                                         '0 : write_ptr_reg + PTR_W'(1);
                        remaining_next = remaining_reg - CNT_W'(1);
                        if (remaining_reg == CNT_W'(1))
                        begin
                            // last byte in: commit the whole write
                            stored_count_next = stored_count_reg + pending_reg;
                            pending_next      = '0;
                        end
                        ok_next = 1'b1;
                    end
                end
                OP_PEEK:
                begin
                    bidx_next = begin_ptr_reg;
                    if (peek_end <= (CNT_W+1)'(CAPACITY))
                    begin
                        s0_next = stored_count_reg;
                    end
                    else
                    begin
                        s0_next = CNT_W'(CAPACITY) - {1'b0, begin_ptr_reg};
                        s1_next = stored_count_reg - (CNT_W'(CAPACITY) - {1'b0, begin_ptr_reg});
                    end
                    ok_next = 1'b1;
                end
                OP_CONSUME:
                begin
                    if (request.consume_length <= stored_count_reg)
                    begin
                        begin_ptr_next = (begin_sum >= (CNT_W+1)'(CAPACITY)) ?
                                         PTR_W'(begin_sum - (CNT_W+1)'(CAPACITY)) :
                                         PTR_W'(begin_sum);
                        stored_count_next = stored_count_reg - request.consume_length;
                        ok_next = 1'b1;
                    end
                end
                OP_READ:
                begin
                    // a 12-bit position always lies inside the ring
                    rd_en       = 1'b1;
                    rd_sel_next = 1'b1;
                    ok_next     = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_ptr_reg    <= '0;
            write_ptr_reg    <= '0;
            stored_count_reg <= '0;
            remaining_reg    <= '0;
            pending_reg      <= '0;
            dropping_reg     <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            begin_ptr_reg    <= begin_ptr_next;
            write_ptr_reg    <= write_ptr_next;
            stored_count_reg <= stored_count_next;
            remaining_reg    <= remaining_next;
            pending_reg      <= pending_next;
            dropping_reg     <= dropping_next;
            done_reg         <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        bidx_reg   <= bidx_next;
        s0_reg     <= s0_next;
        s1_reg     <= s1_next;
        rd_sel_reg <= rd_sel_next;
    end

    // byte store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            byte_store[write_ptr_reg] <= request.data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= byte_store[request.position];
        end
    end

    assign done                   = done_reg;
    assign response.ok            = ok_reg;
    assign response.begin_index   = bidx_reg;
    assign response.slice0_length = s0_reg;
    assign response.slice1_length = s1_reg;
    assign response.read_byte     = rd_sel_reg ? rd_data_reg : 8'd0;

`ifndef SYNTHESIS
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("no result one cycle after an accepted transaction");

    a_reserve_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, stored_count_reg} + {1'b0, pending_reg}) <= (CNT_W+1)'(CAPACITY))
        else $error("committed plus reserved bytes exceed the ring");

    a_remaining_le_pending: assert property (@(posedge clk) disable iff (!rst_n)
        remaining_reg <= pending_reg)
        else $error("bytes still due exceed the open write length");

    a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (remaining_reg == '0) |-> (pending_reg == '0))
        else $error("pending length left after the write finished");
`endif

endmodule
